[hw/rtl/fdri_pkg.sv]
// Shared types and constants for the frame difference ROI intrusion block.
// Holds the pixel and result payload structs, sizes and the register map.
// No dependencies.
package fdri_pkg;

  // Largest frame the previous-frame store holds
  localparam int unsigned MAX_WIDTH  = 512;
  localparam int unsigned MAX_HEIGHT = 512;

  localparam int unsigned COL_W  = $clog2(MAX_WIDTH);
  localparam int unsigned LINE_W = $clog2(MAX_HEIGHT);
  localparam int unsigned ADDR_W = COL_W + LINE_W;
  localparam int unsigned DEPTH  = 2 ** ADDR_W;

  // Fixed register and field widths
  localparam int unsigned CFG_W      = 10;
  localparam int unsigned THR_W      = 8;
  localparam int unsigned COUNT_W    = 19;
  localparam int unsigned CFG_DATA_W = 19;
  localparam int unsigned PIX_W      = 8;

  // Compare widths: room for the position plus one and for a size register
  localparam int unsigned XW = ((COL_W > CFG_W) ? COL_W : CFG_W) + 1;
  localparam int unsigned YW = ((LINE_W > CFG_W) ? LINE_W : CFG_W) + 1;

  // Gray conversion, Q14 weights with rounding
  localparam int unsigned GRAY_SUM_W = 22;
  localparam int unsigned GRAY_SHIFT = 14;
  localparam logic [13:0] W_BLUE     = 14'd1868;
  localparam logic [13:0] W_GREEN    = 14'd9617;
  localparam logic [13:0] W_RED      = 14'd4899;
  localparam logic [13:0] GRAY_ROUND = 14'd8192;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [2:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_ROI_X_START  = 3'd2,
    REG_ROI_X_END    = 3'd3,
    REG_ROI_Y_START  = 3'd4,
    REG_ROI_Y_END    = 3'd5,
    REG_DIFF_THRESH  = 3'd6,
    REG_ALARM_LIMIT  = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;
  } pixel_t;

  typedef struct packed {
    logic               foreground;
    logic               priming_frame;
    logic               frame_done;
    logic               intrusion;
    logic [COUNT_W-1:0] region_count;
  } result_t;

endpackage

[hw/rtl/frame_difference_roi_intrusion.sv]
// Two-frame difference motion detector with region intrusion alarm (top level).
// Holds the pixel pipeline, the previous-frame store and the configuration registers.
// Depends on fdri_pkg.
//
// Pipeline: an accepted pixel passes the input register (s1), then the result register
// that drives out_valid_o. Throughput: one pixel per cycle unless the output stalls;
// the store has one write and one read port.
// Reset: counters, primed flag and valids clear, config registers take their reset
// values at once; the store is not cleared, the first frame after reset fills it.
module frame_difference_roi_intrusion (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // pixel input channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  fdri_pkg::pixel_t                in_data_i,
  // result output channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output fdri_pkg::result_t               out_data_o,
  // configuration write port
  input  logic                            cfg_we_i,
  input  fdri_pkg::cfg_reg_e              cfg_index_i,
  input  logic [fdri_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [fdri_pkg::CFG_W-1:0]   width_q, height_q;
  logic [fdri_pkg::CFG_W-1:0]   roi_xs_q, roi_xe_q, roi_ys_q, roi_ye_q;
  logic [fdri_pkg::THR_W-1:0]   thresh_q;
  logic [fdri_pkg::COUNT_W-1:0] alarm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= fdri_pkg::CFG_W'(320);
      height_q <= fdri_pkg::CFG_W'(240);
      roi_xs_q <= '0;
      roi_xe_q <= '0;
      roi_ys_q <= '0;
      roi_ye_q <= '0;
      thresh_q <= fdri_pkg::THR_W'(30);
      alarm_q  <= fdri_pkg::COUNT_W'(50);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        fdri_pkg::REG_FRAME_WIDTH:  width_q  <= cfg_data_i[fdri_pkg::CFG_W-1:0];
        fdri_pkg::REG_FRAME_HEIGHT: height_q <= cfg_data_i[fdri_pkg::CFG_W-1:0];
        fdri_pkg::REG_ROI_X_START:  roi_xs_q <= cfg_data_i[fdri_pkg::CFG_W-1:0];
        fdri_pkg::REG_ROI_X_END:    roi_xe_q <= cfg_data_i[fdri_pkg::CFG_W-1:0];
        fdri_pkg::REG_ROI_Y_START:  roi_ys_q <= cfg_data_i[fdri_pkg::CFG_W-1:0];
        fdri_pkg::REG_ROI_Y_END:    roi_ye_q <= cfg_data_i[fdri_pkg::CFG_W-1:0];
        fdri_pkg::REG_DIFF_THRESH:  thresh_q <= cfg_data_i[fdri_pkg::THR_W-1:0];
        fdri_pkg::REG_ALARM_LIMIT:  alarm_q  <= cfg_data_i[fdri_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Flow control: input register (s1) feeding the result register.
  // s1 moves on whenever the result register is empty or being drained,
  // so a new pixel is taken every cycle unless the output side stalls.
  // ---------------------------------------------------------------------------
  logic s1_v_q, out_v_q;
  logic out_ready, s1_adv, in_acc;

  assign out_ready  = !out_v_q || !out_stall_i;
  assign s1_adv     = s1_v_q && out_ready;
  assign in_stall_o = s1_v_q && !out_ready;
  assign in_acc     = in_valid_i && !in_stall_o;

  // ---------------------------------------------------------------------------
  // Accept stage: raster position, frame end detect, gray conversion
  // ---------------------------------------------------------------------------
  logic [fdri_pkg::COL_W-1:0]  column_q;
  logic [fdri_pkg::LINE_W-1:0] line_q;
  logic                        primed_q;

  logic [fdri_pkg::XW-1:0]     w_eff;
  logic [fdri_pkg::YW-1:0]     h_eff;
  logic                        last_col, last_line, done;
  logic [fdri_pkg::ADDR_W-1:0] rd_addr;
  logic [fdri_pkg::GRAY_SUM_W-1:0] gray_sum;
  logic [fdri_pkg::PIX_W-1:0]  gray;

  always_comb begin
    // zero acts as one, oversize clamps to the store size
    if (width_q == '0) begin
      w_eff = fdri_pkg::XW'(1);
    end else if (fdri_pkg::XW'(width_q) > fdri_pkg::XW'(fdri_pkg::MAX_WIDTH)) begin
      w_eff = fdri_pkg::XW'(fdri_pkg::MAX_WIDTH);
    end else begin
      w_eff = fdri_pkg::XW'(width_q);
    end
    if (height_q == '0) begin
      h_eff = fdri_pkg::YW'(1);
    end else if (fdri_pkg::YW'(height_q) > fdri_pkg::YW'(fdri_pkg::MAX_HEIGHT)) begin
      h_eff = fdri_pkg::YW'(fdri_pkg::MAX_HEIGHT);
    end else begin
      h_eff = fdri_pkg::YW'(height_q);
    end
  end

  // ">=" so a size shrunk between frames still ends the line/frame
  assign last_col  = (fdri_pkg::XW'(column_q) + fdri_pkg::XW'(1)) >= w_eff;
  assign last_line = (fdri_pkg::YW'(line_q) + fdri_pkg::YW'(1)) >= h_eff;
  assign done      = last_col && last_line;
  assign rd_addr   = {line_q, column_q};

  // constant weights: shift-add multiplies, one adder tree
  assign gray_sum = fdri_pkg::GRAY_SUM_W'(fdri_pkg::W_BLUE)  * fdri_pkg::GRAY_SUM_W'(in_data_i.blue)
                  + fdri_pkg::GRAY_SUM_W'(fdri_pkg::W_GREEN) * fdri_pkg::GRAY_SUM_W'(in_data_i.green)
                  + fdri_pkg::GRAY_SUM_W'(fdri_pkg::W_RED)   * fdri_pkg::GRAY_SUM_W'(in_data_i.red)
                  + fdri_pkg::GRAY_SUM_W'(fdri_pkg::GRAY_ROUND);
  assign gray = gray_sum[fdri_pkg::GRAY_SHIFT +: fdri_pkg::PIX_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_q <= '0;
      line_q   <= '0;
      primed_q <= 1'b0;
    end else if (in_acc) begin
      if (done) begin
        column_q <= '0;
        line_q   <= '0;
        primed_q <= 1'b1;
      end else if (last_col) begin
        column_q <= '0;
        line_q   <= line_q + fdri_pkg::LINE_W'(1);
      end else begin
        column_q <= column_q + fdri_pkg::COL_W'(1);
      end
    end
  end

  // s1 payload
  logic [fdri_pkg::PIX_W-1:0]  s1_gray_q;
  logic [fdri_pkg::COL_W-1:0]  s1_col_q;
  logic [fdri_pkg::LINE_W-1:0] s1_line_q;
  logic [fdri_pkg::ADDR_W-1:0] s1_addr_q;
  logic                        s1_done_q, s1_primed_q;
  logic                        s1_fwd_q;
  logic [fdri_pkg::PIX_W-1:0]  s1_fwd_gray_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (in_acc) begin
      s1_v_q <= 1'b1;
    end else if (s1_adv) begin
      s1_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_gray_q   <= gray;
      s1_col_q    <= column_q;
      s1_line_q   <= line_q;
      s1_addr_q   <= rd_addr;
      s1_done_q   <= done;
      s1_primed_q <= primed_q;
      // one-pixel frame: the pixel ahead writes the entry this one reads
      s1_fwd_q      <= s1_adv && (s1_addr_q == rd_addr);
      s1_fwd_gray_q <= s1_gray_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Previous-frame store: written by s1, read at accept, read data registered
  // ---------------------------------------------------------------------------
  logic [fdri_pkg::PIX_W-1:0] store_mem [fdri_pkg::DEPTH];
  logic [fdri_pkg::PIX_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      store_mem[s1_addr_q] <= s1_gray_q;
    end
    if (in_acc) begin
      rd_data_q <= store_mem[rd_addr];
    end
  end

  // ---------------------------------------------------------------------------
  // Difference stage: threshold, region test, saturating count
  // ---------------------------------------------------------------------------
  logic [fdri_pkg::COUNT_W-1:0] running_q;
  logic [fdri_pkg::PIX_W-1:0]   prev_gray, abs_diff;
  logic                         fg, in_roi;
  logic [fdri_pkg::COUNT_W-1:0] count_next;

  always_comb begin
    prev_gray = s1_fwd_q ? s1_fwd_gray_q : rd_data_q;
    abs_diff  = (s1_gray_q > prev_gray) ? (s1_gray_q - prev_gray) : (prev_gray - s1_gray_q);
    fg        = s1_primed_q && (abs_diff > thresh_q);
    // half-open box; an empty box never matches
    in_roi    = (fdri_pkg::XW'(s1_col_q) >= fdri_pkg::XW'(roi_xs_q))
             && (fdri_pkg::XW'(s1_col_q) <  fdri_pkg::XW'(roi_xe_q))
             && (fdri_pkg::YW'(s1_line_q) >= fdri_pkg::YW'(roi_ys_q))
             && (fdri_pkg::YW'(s1_line_q) <  fdri_pkg::YW'(roi_ye_q));
    if (fg && in_roi && (running_q != fdri_pkg::COUNT_MAX)) begin
      count_next = running_q + fdri_pkg::COUNT_W'(1);
    end else begin
      count_next = running_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= '0;
    end else if (s1_adv) begin
      running_q <= s1_done_q ? '0 : count_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  fdri_pkg::result_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (s1_adv) begin
      out_v_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_q.foreground    <= fg;
      out_q.priming_frame <= !s1_primed_q;
      out_q.frame_done    <= s1_done_q;
      out_q.intrusion     <= s1_done_q && s1_primed_q && (count_next > alarm_q);
      out_q.region_count  <= (s1_done_q && s1_primed_q) ? count_next : '0;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // the count restarts after every frame end transaction
  a_count_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && s1_done_q |=> running_q == '0)
    else $error("region count not cleared at frame end");

  // nothing is flagged or reported during the priming frame
  a_priming_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && out_q.priming_frame |->
      !out_q.foreground && !out_q.intrusion && (out_q.region_count == '0))
    else $error("result reported during priming frame");

  // intrusion and the count only come with a frame end
  a_report_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && !out_q.frame_done |-> !out_q.intrusion && (out_q.region_count == '0))
    else $error("frame report outside frame end");

  // input is held back only when s1 is full and cannot drain
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_v_q && out_v_q && out_stall_i)
    else $error("input stalled without a full pipeline");

endmodule

[tb/sv/tb_frame_difference_roi_intrusion.sv]
// Testbench for frame_difference_roi_intrusion: random and directed BGR pixel streams
// checked against a cycle-free predictor of the gray difference and region count.
// Depends on fdri_pkg and the frame_difference_roi_intrusion RTL.
module tb_frame_difference_roi_intrusion;
  timeunit 1ns;
  timeprecision 1ps;

  // Cycles without any transaction before the run is declared hung
  localparam int unsigned STUCK_LIMIT = 3000;
  // Priming frame size; every later frame stays inside it
  localparam int unsigned PRIME_W = 12;
  localparam int unsigned PRIME_H = 6;

  // ---------------------------------------------------------------------------
  // Clock, reset and block inputs (all known from time zero)
  // ---------------------------------------------------------------------------
  logic                            clk_i     = 1'b0;
  logic                            rst_ni    = 1'b0;
  logic                            in_valid  = 1'b0;
  fdri_pkg::pixel_t                in_data   = '0;
  logic                            out_stall = 1'b0;
  logic                            cfg_we    = 1'b0;
  fdri_pkg::cfg_reg_e              cfg_index = fdri_pkg::REG_FRAME_WIDTH;
  logic [fdri_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  logic                            in_stall_o;
  logic                            out_valid_o;
  fdri_pkg::result_t               out_data_o;

  always #4 clk_i = ~clk_i;

  frame_difference_roi_intrusion dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: own copy of the registers, raster position, region tally
  // and the previous-frame gray store. Register values are the reset values.
  // ---------------------------------------------------------------------------
  logic [fdri_pkg::CFG_W-1:0]   cfg_w     = 10'd320;
  logic [fdri_pkg::CFG_W-1:0]   cfg_h     = 10'd240;
  logic [fdri_pkg::CFG_W-1:0]   roi_xs    = '0;
  logic [fdri_pkg::CFG_W-1:0]   roi_xe    = '0;
  logic [fdri_pkg::CFG_W-1:0]   roi_ys    = '0;
  logic [fdri_pkg::CFG_W-1:0]   roi_ye    = '0;
  logic [fdri_pkg::THR_W-1:0]   diff_thr  = 8'd30;
  logic [fdri_pkg::COUNT_W-1:0] alarm_lim = 19'd50;

  logic [fdri_pkg::COL_W-1:0]   pos_x     = '0;
  logic [fdri_pkg::LINE_W-1:0]  pos_y     = '0;
  logic [fdri_pkg::COUNT_W-1:0] fg_tally  = '0;
  logic                         armed     = 1'b0;   // set once the priming frame is through
  logic [fdri_pkg::PIX_W-1:0]   last_luma [fdri_pkg::DEPTH];

  // Testbench bookkeeping
  fdri_pkg::pixel_t  pixels_to_send [$];
  fdri_pkg::result_t awaited_results [$];
  bit          quiet        = 1'b1;       // no idling on either side while set
  int unsigned stuck        = 0;
  int unsigned errors       = 0;
  int unsigned results_seen = 0;
  int unsigned frames_seen  = 0;
  int unsigned alarms_seen  = 0;

  // Fixed-point BT.601 gray; a pixel with b = g = r = v maps to v exactly
  function automatic logic [fdri_pkg::PIX_W-1:0] luma_of(fdri_pkg::pixel_t px);
    int unsigned sum;
    sum = 1868 * px.blue + 9617 * px.green + 4899 * px.red + 8192;
    return fdri_pkg::PIX_W'(sum >> fdri_pkg::GRAY_SHIFT);
  endfunction

  // Frame size as the block uses it: 0 acts as 1, above the store as the store
  function automatic int unsigned clamp_dim(logic [fdri_pkg::CFG_W-1:0] v,
                                            int unsigned maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  // Expected result for one accepted pixel; advances the predictor state
  function automatic fdri_pkg::result_t forecast_pixel(fdri_pkg::pixel_t px);
    fdri_pkg::result_t          res;
    logic [fdri_pkg::PIX_W-1:0] luma;
    logic [fdri_pkg::PIX_W-1:0] prev;
    logic [fdri_pkg::PIX_W-1:0] diff;
    int unsigned                w;
    int unsigned                h;
    bit                         last_col;
    bit                         last_line;
    res  = '0;
    luma = luma_of(px);
    w    = clamp_dim(cfg_w, fdri_pkg::MAX_WIDTH);
    h    = clamp_dim(cfg_h, fdri_pkg::MAX_HEIGHT);
    res.priming_frame = !armed;
    if (armed) begin
      prev = last_luma[{pos_y, pos_x}];
      diff = (luma > prev) ? luma - prev : prev - luma;
      res.foreground = (diff > diff_thr);
      // half-open region; an empty region (start not below end) never matches
      if (res.foreground && pos_x >= roi_xs && pos_x < roi_xe &&
          pos_y >= roi_ys && pos_y < roi_ye && fg_tally != fdri_pkg::COUNT_MAX) begin
        fg_tally = fg_tally + 1'b1;
      end
    end
    last_luma[{pos_y, pos_x}] = luma;
    // ">=" so a size shrunk mid-frame ends the line / frame at once
    last_col  = (pos_x + 1 >= w);
    last_line = (pos_y + 1 >= h);
    if (last_col && last_line) begin
      res.frame_done = 1'b1;
      if (armed) begin
        res.region_count = fg_tally;
        res.intrusion    = (fg_tally > alarm_lim);
      end
      fg_tally = '0;
      armed    = 1'b1;
      pos_x    = '0;
      pos_y    = '0;
    end else if (last_col) begin
      pos_x = '0;
      pos_y = pos_y + 1'b1;
    end else begin
      pos_x = pos_x + 1'b1;
    end
    return res;
  endfunction

  // Idles with a chance of about 34 in a hundred, never while quiet
  function automatic bit take_break();
    return !quiet && ($urandom_range(99) < 34);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: pixel transactions from pixels_to_send. The expectation is formed
  // at the edge where the transaction is accepted, so register state matches.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall_o) begin
        awaited_results.push_back(forecast_pixel(in_data));
      end
      // a stalled payload holds; otherwise load the next one or idle
      if (!in_valid || !in_stall_o) begin
        if (pixels_to_send.size() != 0 && !take_break()) begin
          in_valid <= 1'b1;
          in_data  <= pixels_to_send.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: every result transaction against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    fdri_pkg::result_t want;
    bit                bad;
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall) begin
        if (awaited_results.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("unexpected result transaction: fg %0b prime %0b done %0b intr %0b cnt %0d",
                     out_data_o.foreground, out_data_o.priming_frame, out_data_o.frame_done,
                     out_data_o.intrusion, out_data_o.region_count);
          end
        end else begin
          want = awaited_results.pop_front();
          results_seen++;
          if (want.frame_done && !want.priming_frame) frames_seen++;
          if (want.intrusion) alarms_seen++;
          bad = (out_data_o.foreground    !== want.foreground)    ||
                (out_data_o.priming_frame !== want.priming_frame) ||
                (out_data_o.frame_done    !== want.frame_done)    ||
                (out_data_o.intrusion     !== want.intrusion)     ||
                (out_data_o.region_count  !== want.region_count);
          if (bad) begin
            errors++;
            if (errors <= 10) begin
              $write("mismatch on result %0d (exp/act): fg %0b/%0b prime %0b/%0b ",
                     results_seen, want.foreground, out_data_o.foreground,
                     want.priming_frame, out_data_o.priming_frame);
              $display("done %0b/%0b intr %0b/%0b cnt %0d/%0d",
                       want.frame_done, out_data_o.frame_done,
                       want.intrusion, out_data_o.intrusion,
                       want.region_count, out_data_o.region_count);
            end
          end
        end
      end
      out_stall <= take_break();
    end
  end

  // Hang detection: cycles with neither channel moving a transaction
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall)) stuck <= 0;
    else stuck <= stuck + 1;
  end

  initial begin
    while (stuck < STUCK_LIMIT) @(posedge clk_i);
    $display("timeout: no transaction for %0d cycles", STUCK_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic wait_idle();
    @(posedge clk_i);
    while (pixels_to_send.size() != 0 || in_valid || awaited_results.size() != 0)
      @(posedge clk_i);
  endtask

  // One register write; the predictor copy follows at the sampling edge
  task automatic write_reg(fdri_pkg::cfg_reg_e idx, logic [fdri_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    case (idx)
      fdri_pkg::REG_FRAME_WIDTH:  cfg_w     = val[fdri_pkg::CFG_W-1:0];
      fdri_pkg::REG_FRAME_HEIGHT: cfg_h     = val[fdri_pkg::CFG_W-1:0];
      fdri_pkg::REG_ROI_X_START:  roi_xs    = val[fdri_pkg::CFG_W-1:0];
      fdri_pkg::REG_ROI_X_END:    roi_xe    = val[fdri_pkg::CFG_W-1:0];
      fdri_pkg::REG_ROI_Y_START:  roi_ys    = val[fdri_pkg::CFG_W-1:0];
      fdri_pkg::REG_ROI_Y_END:    roi_ye    = val[fdri_pkg::CFG_W-1:0];
      fdri_pkg::REG_DIFF_THRESH:  diff_thr  = val[fdri_pkg::THR_W-1:0];
      fdri_pkg::REG_ALARM_LIMIT:  alarm_lim = val[fdri_pkg::COUNT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_settings(int unsigned w, int unsigned h, int unsigned xs,
                               int unsigned xe, int unsigned ys, int unsigned ye,
                               int unsigned thr, int unsigned alarm);
    write_reg(fdri_pkg::REG_FRAME_WIDTH,  fdri_pkg::CFG_DATA_W'(w));
    write_reg(fdri_pkg::REG_FRAME_HEIGHT, fdri_pkg::CFG_DATA_W'(h));
    write_reg(fdri_pkg::REG_ROI_X_START,  fdri_pkg::CFG_DATA_W'(xs));
    write_reg(fdri_pkg::REG_ROI_X_END,    fdri_pkg::CFG_DATA_W'(xe));
    write_reg(fdri_pkg::REG_ROI_Y_START,  fdri_pkg::CFG_DATA_W'(ys));
    write_reg(fdri_pkg::REG_ROI_Y_END,    fdri_pkg::CFG_DATA_W'(ye));
    write_reg(fdri_pkg::REG_DIFF_THRESH,  fdri_pkg::CFG_DATA_W'(thr));
    write_reg(fdri_pkg::REG_ALARM_LIMIT,  fdri_pkg::CFG_DATA_W'(alarm));
  endtask

  task automatic queue_px(logic [7:0] b, logic [7:0] g, logic [7:0] r);
    pixels_to_send.push_back(fdri_pkg::pixel_t'{b, g, r});
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [23:0]      raw;
    fdri_pkg::pixel_t px;
    int          planned [int];   // gray queued for a position earlier in this phase
    int unsigned w_val, h_val, ew, eh, xs, xe, ys, ye, thr, alarm, frames, addr;
    int unsigned rand_items;
    int unsigned phase;
    int          base, v, mode;
    rand_items = 0;
    phase      = 0;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Priming frame over the largest area any later frame uses, so no later
    // frame can read a position that was never written.
    // It runs without idling: the long uninterrupted stretch of the run.
    load_settings(PRIME_W, PRIME_H, 0, 512, 0, 512, 30, 50);
    for (int i = 0; i < PRIME_W * PRIME_H; i++) begin
      raw = $urandom;
      px  = raw;
      pixels_to_send.push_back(px);
    end
    wait_idle();
    quiet = 1'b0;

    // Directed: color extremes in a 4x2 frame, region [1,3) x [0,2), any change
    // counts, alarm limit zero
    load_settings(4, 2, 1, 3, 0, 2, 0, 0);
    queue_px(8'd0,   8'd0,   8'd0);
    queue_px(8'd255, 8'd255, 8'd255);
    queue_px(8'd255, 8'd0,   8'd0);
    queue_px(8'd0,   8'd255, 8'd0);
    queue_px(8'd0,   8'd0,   8'd255);
    queue_px(8'd255, 8'd255, 8'd255);
    queue_px(8'd0,   8'd0,   8'd0);
    queue_px(8'd128, 8'd128, 8'd128);
    wait_idle();
    // Inverted frame, threshold 254: only full-scale swings are foreground
    load_settings(4, 2, 0, 512, 0, 512, 254, 1);
    queue_px(8'd255, 8'd255, 8'd255);
    queue_px(8'd0,   8'd0,   8'd0);
    queue_px(8'd0,   8'd255, 8'd255);
    queue_px(8'd255, 8'd0,   8'd255);
    queue_px(8'd255, 8'd255, 8'd0);
    queue_px(8'd0,   8'd0,   8'd0);
    queue_px(8'd255, 8'd255, 8'd255);
    queue_px(8'd127, 8'd127, 8'd127);
    wait_idle();
    // Zero sizes act as 1: one-pixel frames; empty region (start past end)
    load_settings(0, 0, 5, 2, 0, 512, 0, 0);
    queue_px(8'd0,   8'd0,   8'd0);
    queue_px(8'd255, 8'd255, 8'd255);
    wait_idle();
    // Size shrunk mid-frame: column and line already past the new ends
    load_settings(6, 4, 0, 512, 0, 512, 0, 3);
    for (int i = 0; i < 8; i++) begin
      raw = $urandom;
      queue_px(raw[7:0], raw[15:8], raw[23:16]);
    end
    wait_idle();
    write_reg(fdri_pkg::REG_FRAME_WIDTH,  fdri_pkg::CFG_DATA_W'(2));
    write_reg(fdri_pkg::REG_FRAME_HEIGHT, fdri_pkg::CFG_DATA_W'(1));
    queue_px(8'd200, 8'd10, 8'd90);
    wait_idle();

    // Random phases: new settings, then one to three whole frames
    while (rand_items < 280) begin
      phase++;
      w_val = ($urandom_range(99) < 8) ? 0 : $urandom_range(1, PRIME_W);
      h_val = ($urandom_range(99) < 8) ? 0 : $urandom_range(1, PRIME_H);
      if (phase == 2) begin
        w_val = PRIME_W;    // widest line
        h_val = 1;
      end else if (phase == 4) begin
        w_val = 1;          // tallest frame
        h_val = PRIME_H;
      end
      ew = clamp_dim(fdri_pkg::CFG_W'(w_val), fdri_pkg::MAX_WIDTH);
      eh = clamp_dim(fdri_pkg::CFG_W'(h_val), fdri_pkg::MAX_HEIGHT);

      xs = $urandom_range(0, ew + 1);
      xe = ($urandom_range(99) < 80) ? $urandom_range(xs, ew + 2) : $urandom_range(0, ew + 1);
      ys = $urandom_range(0, eh + 1);
      ye = ($urandom_range(99) < 80) ? $urandom_range(ys, eh + 2) : $urandom_range(0, eh + 1);
      mode = $urandom_range(99);
      if (mode < 10) xe = 512;
      else if (mode < 15) xe = 1023;
      else if (mode < 20) xs = 1023;
      mode = $urandom_range(99);
      if (mode < 10) ye = 512;
      else if (mode < 15) ye = 1023;
      else if (mode < 20) ys = 1023;

      mode = $urandom_range(99);
      if (mode < 10) thr = 0;
      else if (mode < 20) thr = 255;
      else thr = $urandom_range(0, 60);

      mode = $urandom_range(99);
      if (mode < 10) alarm = 0;
      else if (mode < 20) alarm = fdri_pkg::COUNT_MAX;
      else if (mode < 30) alarm = $urandom & fdri_pkg::COUNT_MAX;
      else alarm = $urandom_range(0, ew * eh / 2 + 1);

      quiet = (phase == 6);
      frames = $urandom_range(1, 3);

      // Holds off until every expected result is in, then reconfigures
      wait_idle();
      load_settings(w_val, h_val, xs, xe, ys, ye, thr, alarm);
      planned.delete();
      for (int f = 0; f < frames; f++) begin
        for (int y = 0; y < eh; y++) begin
          for (int x = 0; x < ew; x++) begin
            addr = y * fdri_pkg::MAX_WIDTH + x;
            base = planned.exists(addr) ? planned[addr] : last_luma[addr];
            mode = $urandom_range(99);
            if (mode < 30) begin
              raw = $urandom;       // arbitrary color
              px  = raw;
            end else begin
              if (mode < 55) begin
                v = base;           // unchanged gray
              end else begin
                // just at or just past the threshold, either direction
                v = base + ((mode & 1) ? -1 : 1) * int'(thr + $urandom_range(0, 1));
                if (v < 0) v = 0;
                if (v > 255) v = 255;
              end
              px = fdri_pkg::pixel_t'{v[7:0], v[7:0], v[7:0]};
            end
            planned[addr] = luma_of(px);
            pixels_to_send.push_back(px);
            rand_items++;
          end
        end
      end
    end

    wait_idle();
    repeat (16) @(posedge clk_i);

    $display("Checked %0d pixel results, %0d primed frames completed, %0d raised intrusion",
             results_seen, frames_seen, alarms_seen);
    $display("Random part: %0d setting phases, %0d pixels; %0d mismatches",
             phase, rand_items, errors);
    if (errors == 0 && awaited_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/fdri_pkg.sv
hw/rtl/frame_difference_roi_intrusion.sv
tb/sv/tb_frame_difference_roi_intrusion.sv
